### sv/pcws_pkg.sv
`default_nettype none
package pcws_pkg;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] CV_OK   = 2'd0;
  localparam logic [1:0] CV_FEW  = 2'd1;
  localparam logic [1:0] CV_ZERO = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic        [15:0] cell_index;
    logic signed [15:0] sample;
  } req_t;

  typedef struct packed {
    logic [15:0] out_cell;
    logic [30:0] mean_value;
    logic [15:0] sample_total;
    logic [31:0] variation_coeff;
    logic [1:0]  cv_status;
  } rsp_t;

endpackage
`default_nettype wire

### sv/pcws_ram.sv
`default_nettype none
module pcws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/per_cell_welford_statistics.sv
// Accumulate request: read, 64-step divide, multiply, write back; the next
//   request is accepted once the write-back is done.
// Readout request: read, divide, 40-step square root, divide, finish; the
//   next request is accepted once the result is staged.
// One request at a time; the result register frees the input during out stall.
// Reset: async, active low; a clearing pass zeroes memory, cfg = 2.
`default_nettype none
module per_cell_welford_statistics #(
  parameter int CELLS      = 65536,
  parameter int COUNT_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire pcws_pkg::req_t  in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output pcws_pkg::rsp_t       out_rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i
);

  localparam int AW = $clog2(CELLS);
  localparam int EW = COUNT_BITS + 32 + 64;

  // Sequencer, one-hot
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_WB    = 8'b0010_0000,
    S_SQRT  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  // What the shared divider is computing
  typedef enum logic [1:0] {
    M_MEAN = 2'd0,
    M_VAR  = 2'd1,
    M_CV   = 2'd2
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [15:0] cfg_q;
  logic [6:0]  iter_q, iter_d;
  logic        out_valid_q, out_valid_d;

  // request and entry copies
  logic                  op_q, op_d;
  logic [15:0]           cell_q, cell_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [30:0]           xq_q, xq_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [31:0]           mean_q, mean_d;
  logic [63:0]           m2_q, m2_d;
  logic                  neg_q, neg_d;
  logic [31:0]           ad1_q, ad1_d;
  logic [31:0]           ad2_q, ad2_d;
  logic [63:0]           prod_q, prod_d;

  // divider
  logic [63:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d, rem_q, rem_d;
  // square root
  logic [79:0] sop_q, sop_d;
  logic [39:0] root_q, root_d;
  logic [43:0] srem_q, srem_d;

  // staged result
  logic [31:0] rcv_q, rcv_d;
  logic [1:0]  rst_q, rst_d;
  pcws_pkg::rsp_t out_q, out_d;

  // memory
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  pcws_ram #(.Width(EW), .Depth(CELLS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(addr_d),
    .rdata_o(mem_rdata)
  );

  logic                  accept;
  logic                  in_range;
  logic [COUNT_BITS-1:0] r_cnt, n_inc;
  logic [31:0]           r_mean;
  logic [63:0]           r_m2;
  logic signed [32:0]    d1, d2;
  logic [31:0]           mean_new;
  logic [32:0]           dstep;
  logic                  dge;
  logic [43:0]           sstep, strial;
  logic                  sge;
  logic [64:0]           inc, m2sum;
  logic [31:0]           cnt32;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_range = 32'(in_req_i.cell_index) < 32'(CELLS);
  assign in_stall_o = (state_q != S_IDLE);

  assign {r_m2, r_mean, r_cnt} = mem_rdata;
  assign n_inc = r_cnt + COUNT_BITS'(1);
  assign d1 = $signed({2'b00, xq_q}) - $signed({1'b0, r_mean});
  assign mean_new = neg_q ? (mean_q - quo_q[31:0]) : (mean_q + quo_q[31:0]);
  assign d2 = $signed({2'b00, xq_q}) - $signed({1'b0, mean_new});

  // restoring divide step
  assign dstep = {rem_q, dvd_q[63]};
  assign dge   = dstep >= {1'b0, dvs_q};
  // square-root step
  assign sstep  = {srem_q[41:0], sop_q[79:78]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = sstep >= strial;

  assign inc   = (65'(prod_q) + 65'd32768) >> 16;
  assign m2sum = 65'(m2_q) + inc;
  assign cnt32 = 32'(cnt_q);

  always_comb begin
    state_d = state_q;  mode_d = mode_q;  clr_d = clr_q;  iter_d = iter_q;
    op_d = op_q;  cell_d = cell_q;  addr_d = addr_q;  xq_d = xq_q;
    cnt_d = cnt_q;  mean_d = mean_q;  m2_d = m2_q;  neg_d = neg_q;
    ad1_d = ad1_q;  ad2_d = ad2_q;  prod_d = prod_q;
    dvd_d = dvd_q;  quo_d = quo_q;  dvs_d = dvs_q;  rem_d = rem_q;
    sop_d = sop_q;  root_d = root_q;  srem_d = srem_q;
    rcv_d = rcv_q;  rst_d = rst_q;  out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we = 1'b0;  mem_re = 1'b0;
    mem_waddr = addr_q;  mem_wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d   = in_req_i.opcode;
          cell_d = in_req_i.cell_index;
          addr_d = AW'(32'(in_req_i.cell_index));
          xq_d   = {in_req_i.sample[14:0], 16'd0};
          if (in_req_i.opcode == pcws_pkg::OP_ACC) begin
            // no-data samples and stray cells leave nothing to do
            if (!in_req_i.sample[15] && in_range) begin
              mem_re  = 1'b1;
              state_d = S_READ;
            end
          end else if (in_range) begin
            mem_re  = 1'b1;
            state_d = S_READ;
          end else begin
            cnt_d = '0;  mean_d = '0;  rcv_d = '0;
            rst_d = pcws_pkg::CV_FEW;
            state_d = S_FIN;
          end
        end
      end
      S_READ: begin
        cnt_d = r_cnt;  mean_d = r_mean;  m2_d = r_m2;
        rem_d = '0;  quo_d = '0;  iter_d = '0;
        if (op_q == pcws_pkg::OP_ACC) begin
          if (r_cnt == {COUNT_BITS{1'b1}}) begin
            state_d = S_IDLE;  // saturated count freezes the cell
          end else begin
            neg_d  = d1[32];
            ad1_d  = d1[32] ? 32'(-d1) : d1[31:0];
            dvd_d  = 64'(d1[32] ? 32'(-d1) : d1[31:0]) + 64'(n_inc >> 1);
            dvs_d  = 32'(n_inc);
            cnt_d  = n_inc;
            mode_d = M_MEAN;
            state_d = S_DIV;
          end
        end else if (32'(r_cnt) <= 32'(cfg_q) || 32'(r_cnt) <= 32'd1) begin
          rcv_d = '0;  rst_d = pcws_pkg::CV_FEW;  state_d = S_FIN;
        end else if (r_mean == '0) begin
          rcv_d = '0;  rst_d = pcws_pkg::CV_ZERO;  state_d = S_FIN;
        end else begin
          dvd_d  = r_m2;
          dvs_d  = 32'(r_cnt - COUNT_BITS'(1));
          mode_d = M_VAR;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = dge ? 32'(dstep - {1'b0, dvs_q}) : dstep[31:0];
        quo_d  = {quo_q[62:0], dge};
        dvd_d  = {dvd_q[62:0], 1'b0};
        iter_d = iter_q + 7'd1;
        if (iter_q == 7'd64) begin
          iter_d = '0;  rem_d = rem_q;  quo_d = quo_q;  dvd_d = dvd_q;
          case (mode_q)
            M_MEAN: begin
              mean_d = mean_new;
              ad2_d  = d2[32] ? 32'(-d2) : d2[31:0];
              state_d = S_MUL;
            end
            M_VAR: begin
              sop_d  = {quo_q, 16'd0};
              root_d = '0;  srem_d = '0;
              state_d = S_SQRT;
            end
            default: begin
              rcv_d = (quo_q[63:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0];
              rst_d = pcws_pkg::CV_OK;
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_SQRT: begin
        srem_d = sge ? (sstep - strial) : sstep;
        root_d = {root_q[38:0], sge};
        sop_d  = {sop_q[77:0], 2'b00};
        iter_d = iter_q + 7'd1;
        if (iter_q == 7'd39) begin
          iter_d = '0;
        end
        if (iter_q == 7'd40) begin
          iter_d = '0;  srem_d = srem_q;  root_d = root_q;  sop_d = sop_q;
          dvd_d  = 64'({root_q, 16'd0});
          dvs_d  = mean_q;
          rem_d  = '0;  quo_d = '0;
          mode_d = M_CV;
          state_d = S_DIV;
        end else if (iter_q == 7'd39) begin
          iter_d = 7'd40;
        end
      end
      S_MUL: begin
        prod_d  = 64'(ad1_q) * 64'(ad2_q);
        state_d = S_WB;
      end
      S_WB: begin
        mem_we = 1'b1;
        mem_wdata = {(m2sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2sum[63:0]), mean_q, cnt_q};
        state_d = S_IDLE;
      end
      S_FIN: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_d.out_cell        = cell_q;
          out_d.mean_value      = mean_q[30:0];
          out_d.sample_total    = (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
          out_d.variation_coeff = rcv_q;
          out_d.cv_status       = rst_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= M_MEAN;
      clr_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= 16'd2;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      clr_q       <= clr_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  cell_q <= cell_d;  addr_q <= addr_d;  xq_q <= xq_d;
    cnt_q <= cnt_d;  mean_q <= mean_d;  m2_q <= m2_d;  neg_q <= neg_d;
    ad1_q <= ad1_d;  ad2_q <= ad2_d;  prod_q <= prod_d;
    dvd_q <= dvd_d;  quo_q <= quo_d;  dvs_q <= dvs_d;  rem_q <= rem_d;
    sop_q <= sop_d;  root_q <= root_d;  srem_q <= srem_d;
    rcv_q <= rcv_d;  rst_q <= rst_d;  out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // memory is written only by the clearing pass or the write-back step
  a_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_WB))
    else $error("cell memory written outside clear/write-back");

  // a new result appears only out of the finish step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised without finish step");

  // clearing pass keeps requests out
  a_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("request accepted during clearing pass");

endmodule
`default_nettype wire

### verif/tb_per_cell_welford_statistics.sv
`default_nettype none
module tb_per_cell_welford_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest request is a readout; the drain margin covers a
  // trailing accumulate that produces no result.
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS  = 10;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  pcws_pkg::req_t in_req_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  pcws_pkg::rsp_t out_rsp_o;
  logic           cfg_we_i = 1'b0;
  logic [15:0]    cfg_wdata_i = 16'd0;

  always #1 clk_i = ~clk_i;

  per_cell_welford_statistics u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow copy of per-cell statistics and the threshold register.
  bit [15:0]   cell_count [65536];
  bit [31:0]   cell_mean  [65536];
  bit [63:0]   cell_sqdev [65536];
  bit [15:0]   cv_min_count = 16'd2;

  pcws_pkg::rsp_t pending_readouts[$];
  int          mismatches = 0;
  int          readouts_seen = 0;
  int          requests_sent = 0;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;

  // Signed divide, rounded to nearest with ties away from zero.
  function automatic longint round_div(longint a, longint n);
    longint mag;
    mag = (a < 0) ? -a : a;
    mag = (mag + n / 2) / n;
    return (a < 0) ? -mag : mag;
  endfunction

  // Floor square root of an 80-bit value, two bits per step.
  function automatic bit [63:0] floor_sqrt80(bit [79:0] v);
    bit [63:0] root;
    bit [63:0] rem;
    bit [63:0] trial;
    root = 0;
    rem  = 0;
    for (int p = 39; p >= 0; p--) begin
      rem   = (rem << 2) | v[2*p +: 2];
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Welford update of one cell; no-data samples and full counters are skipped.
  function automatic void welford_update(bit [15:0] c, logic signed [15:0] s);
    longint    n, xq, m, d1, d2;
    bit [63:0] prod, inc;
    if (s < 0 || cell_count[c] == 16'hFFFF) return;
    n  = longint'(cell_count[c]) + 1;
    cell_count[c] = n[15:0];
    xq = longint'(s) * 65536;
    m  = longint'(cell_mean[c]);
    d1 = xq - m;
    m  = m + round_div(d1, n);
    cell_mean[c] = m[31:0];
    d2 = xq - m;
    prod = 64'((d1 < 0) ? -d1 : d1) * 64'((d2 < 0) ? -d2 : d2);
    inc  = (prod + 64'd32768) >> 16;
    cell_sqdev[c] = (cell_sqdev[c] > ~inc) ? '1 : cell_sqdev[c] + inc;
  endfunction

  function automatic pcws_pkg::rsp_t cell_readout(bit [15:0] c);
    pcws_pkg::rsp_t r;
    bit [63:0]      var_q, sd, cv;
    r = '0;
    r.out_cell     = c;
    r.mean_value   = cell_mean[c][30:0];
    r.sample_total = cell_count[c];
    if (cell_count[c] <= cv_min_count || cell_count[c] <= 1) begin
      r.cv_status = pcws_pkg::CV_FEW;
    end else if (cell_mean[c] == 0) begin
      r.cv_status = pcws_pkg::CV_ZERO;
    end else begin
      var_q = cell_sqdev[c] / (64'(cell_count[c]) - 1);
      sd    = floor_sqrt80({var_q, 16'd0});
      cv    = (sd << 16) / 64'(cell_mean[c]);
      r.variation_coeff = (cv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cv[31:0];
      r.cv_status = pcws_pkg::CV_OK;
    end
    return r;
  endfunction

  // Drive one request and wait for acceptance; the prediction is made at
  // the accepting edge so expectation order matches request order.
  task automatic send_request(pcws_pkg::req_t r, bit typed, pcws_pkg::rsp_t typed_rsp);
    pcws_pkg::rsp_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
    if (r.opcode == pcws_pkg::OP_ACC) begin
      welford_update(r.cell_index, r.sample);
    end else begin
      pred = cell_readout(r.cell_index);
      pending_readouts.push_back(typed ? typed_rsp : pred);
    end
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait for every outstanding readout, then let any trailing accumulate finish.
  task automatic drain();
    idle_input();
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(bit [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cv_min_count = v;
  endtask

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    pcws_pkg::rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      readouts_seen++;
      if (pending_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected readout: cell %0d", out_rsp_o.out_cell);
      end else begin
        exp_rsp = pending_readouts.pop_front();
        if (out_rsp_o.out_cell !== exp_rsp.out_cell ||
            out_rsp_o.mean_value !== exp_rsp.mean_value ||
            out_rsp_o.sample_total !== exp_rsp.sample_total ||
            out_rsp_o.variation_coeff !== exp_rsp.variation_coeff ||
            out_rsp_o.cv_status !== exp_rsp.cv_status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("readout mismatch: exp cell %0d mean %h n %0d cv %h st %0d",
                     exp_rsp.out_cell, exp_rsp.mean_value, exp_rsp.sample_total,
                     exp_rsp.variation_coeff, exp_rsp.cv_status);
            $display("                  got cell %0d mean %h n %0d cv %h st %0d",
                     out_rsp_o.out_cell, out_rsp_o.mean_value, out_rsp_o.sample_total,
                     out_rsp_o.variation_coeff, out_rsp_o.cv_status);
          end
        end
      end
    end
  end

  // Directed table: opcode, cell, sample, typed flag, typed readout.
  typedef struct {
    logic               op;
    bit [15:0]          cell_idx;
    logic signed [15:0] smp;
    bit                 typed;
    pcws_pkg::rsp_t     rsp;
  } vector_t;

  localparam int NUM_VECTORS = 22;
  vector_t vectors [NUM_VECTORS];

  initial begin
    vectors = '{
      // Cleared cells read back empty, both ends of the index range.
      '{pcws_pkg::OP_READ, 16'd0,    16'sd0,      1,
        '{16'd0, 31'd0, 16'd0, 32'd0, pcws_pkg::CV_FEW}},
      '{pcws_pkg::OP_READ, 16'hFFFF, 16'sd0,      1,
        '{16'hFFFF, 31'd0, 16'd0, 32'd0, pcws_pkg::CV_FEW}},
      // No-data samples leave the cell untouched.
      '{pcws_pkg::OP_ACC,  16'd1,    -16'sd1,     0, '0},
      '{pcws_pkg::OP_ACC,  16'd1,    -16'sd32768, 0, '0},
      '{pcws_pkg::OP_READ, 16'd1,    16'sd0,      1,
        '{16'd1, 31'd0, 16'd0, 32'd0, pcws_pkg::CV_FEW}},
      // Largest sample; two samples is still at the threshold.
      '{pcws_pkg::OP_ACC,  16'd2,    16'sd32767,  0, '0},
      '{pcws_pkg::OP_ACC,  16'd2,    16'sd32767,  0, '0},
      '{pcws_pkg::OP_READ, 16'd2,    16'sd0,      1,
        '{16'd2, 31'h7FFF0000, 16'd2, 32'd0, pcws_pkg::CV_FEW}},
      '{pcws_pkg::OP_ACC,  16'd2,    16'sd32767,  0, '0},
      '{pcws_pkg::OP_READ, 16'd2,    16'sd0,      1,
        '{16'd2, 31'h7FFF0000, 16'd3, 32'd0, pcws_pkg::CV_OK}},
      // All-zero samples give a zero mean.
      '{pcws_pkg::OP_ACC,  16'd3,    16'sd0,      0, '0},
      '{pcws_pkg::OP_ACC,  16'd3,    16'sd0,      0, '0},
      '{pcws_pkg::OP_ACC,  16'd3,    16'sd0,      0, '0},
      '{pcws_pkg::OP_READ, 16'd3,    16'sd0,      1,
        '{16'd3, 31'd0, 16'd3, 32'd0, pcws_pkg::CV_ZERO}},
      // Wide spread, checked by prediction.
      '{pcws_pkg::OP_ACC,  16'd4,    16'sd0,      0, '0},
      '{pcws_pkg::OP_ACC,  16'd4,    16'sd32767,  0, '0},
      '{pcws_pkg::OP_ACC,  16'd4,    16'sd0,      0, '0},
      '{pcws_pkg::OP_READ, 16'd4,    16'sd0,      0, '0},
      '{pcws_pkg::OP_ACC,  16'hFFFF, 16'sd1,      0, '0},
      '{pcws_pkg::OP_ACC,  16'hFFFF, 16'sd1000,   0, '0},
      '{pcws_pkg::OP_ACC,  16'hFFFF, 16'sd7,      0, '0},
      '{pcws_pkg::OP_READ, 16'hFFFF, 16'sd0,      0, '0}
    };
  end

  function automatic pcws_pkg::req_t random_request();
    pcws_pkg::req_t r;
    int             pick;
    r.opcode = ($urandom_range(99) < 30) ? pcws_pkg::OP_READ : pcws_pkg::OP_ACC;
    pick = $urandom_range(99);
    // A small pool of hot cells lets counts grow; some wild indexes
    // toggle every bit of the index.
    if (pick < 80)      r.cell_index = 16'(16 + $urandom_range(11));
    else if (pick < 90) r.cell_index = 16'($urandom);
    else                r.cell_index = ($urandom_range(1)) ? 16'hFFFF : 16'h8000;
    pick = $urandom_range(99);
    if (pick < 70)      r.sample = 16'($urandom_range(32767));
    else if (pick < 80) r.sample = 16'($urandom_range(200));
    else if (pick < 90) r.sample = 16'($urandom) | 16'h8000;
    else                r.sample = ($urandom_range(1)) ? 16'sh7FFF : 16'sd0;
    return r;
  endfunction

  initial begin
    pcws_pkg::req_t r;
    int   idle_plan  [4] = '{0, 84, 0, 38};
    int   stall_plan [4] = '{0, 0, 84, 38};
    bit [15:0] thresholds [4];

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks at the reset threshold.
    for (int i = 0; i < NUM_VECTORS; i++) begin
      r.opcode     = vectors[i].op;
      r.cell_index = vectors[i].cell_idx;
      r.sample     = vectors[i].smp;
      send_request(r, vectors[i].typed, vectors[i].rsp);
    end
    drain();

    thresholds = '{16'd0, 16'hFFFF, 16'(3 + $urandom_range(5)), 16'd2};
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thresholds[ph]);
      sender_idle_pct = idle_plan[ph];
      stall_pct       = stall_plan[ph];
      for (int k = 0; k < 225; k++) begin
        r = random_request();
        send_request(r, 1'b0, '0);
      end
      // Sender holds off here until all readouts are back.
      drain();
    end
    stall_pct = 0;

    $display("Sent %0d requests and checked %0d readouts over four traffic phases",
             requests_sent, readouts_seen);
    $display("and four threshold settings including 0 and 65535.");
    if (mismatches == 0 && pending_readouts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d readouts missing", mismatches, pending_readouts.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: clearing pass plus worst-case request and stall time, with margin.
  initial begin
    #10ms;
    $display("timeout waiting on handshake");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
sv/pcws_pkg.sv
sv/pcws_ram.sv
sv/per_cell_welford_statistics.sv
verif/tb_per_cell_welford_statistics.sv
